>>> sv/avtab_pkg.sv
package avtab_pkg;

  localparam int FRAME_SIZE_BITS_DEF = 24;
  localparam int CMD_FIFO_AW_DEF     = 2;

  // One accepted frame byte, classified: what the back end must emit for it.
  typedef struct packed {
    logic [7:0] data;
    logic       start_code;   // emit 00 00 00 01 on the Annex-B channel
    logic       annexb_byte;  // emit data on the Annex-B channel
    logic       filler;       // emit the 16-byte filler unit on the relay channel
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  // Filler unit: length 12, header 0x0C, ten 0xFF, trailing 0x80.
  function automatic logic [7:0] filler_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0, 4'd1, 4'd2: b = 8'h00;
      4'd3, 4'd4:       b = 8'h0C;
      4'd15:            b = 8'h80;
      default:          b = 8'hFF;
    endcase
    return b;
  endfunction

endpackage

>>> sv/avtab_fifo.sv
module avtab_fifo
  import avtab_pkg::*;
#(
  parameter int W  = CMD_W,
  parameter int AW = CMD_FIFO_AW_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int DEPTH = 1 << AW;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full || rd_en)
    else $error("fifo written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("fifo read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("fifo count beyond depth");

endmodule

>>> sv/avtab_front.sv
module avtab_front
  import avtab_pkg::*;
#(
  parameter int FRAME_SIZE_BITS = FRAME_SIZE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_first_byte,
  input  logic [FRAME_SIZE_BITS-1:0] in_frame_size,
  output logic                       push,
  output cmd_t                       push_cmd,
  input  logic                       fifo_full
);

  localparam logic [1:0] PH_LENGTH  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_STOPPED = 2'd2;

  logic                       en_r;
  logic [1:0]                 phase_r, phase_nxt;
  logic [1:0]                 lbc_r, lbc_nxt;
  logic [23:0]                ul_r, ul_nxt;
  logic [31:0]                pl_r, pl_nxt;
  logic [FRAME_SIZE_BITS-1:0] fl_r, fl_nxt;

  logic                       accept;
  logic                       drop;
  logic [1:0]                 phase_eff;
  logic [1:0]                 lbc_eff;
  logic [23:0]                ul_eff;
  logic [FRAME_SIZE_BITS-1:0] fl_eff;
  logic [FRAME_SIZE_BITS-1:0] fl_dec;
  logic [31:0]                ul_new;
  logic [31:0]                pl_dec;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !in_stall;
  assign drop     = !in_first_byte && (fl_r == '0);
  assign push     = accept && !drop;

  always_comb begin
    // A first byte restarts all parsing before the byte is looked at.
    phase_eff = in_first_byte ? PH_LENGTH : phase_r;
    lbc_eff   = in_first_byte ? 2'd0 : lbc_r;
    ul_eff    = in_first_byte ? 24'd0 : ul_r;
    if (in_first_byte) begin
      fl_eff = (in_frame_size == '0) ? FRAME_SIZE_BITS'(1) : in_frame_size;
    end else begin
      fl_eff = fl_r;
    end
    fl_dec = fl_eff - 1'b1;
    ul_new = {ul_eff, in_data_byte};
    pl_dec = (pl_r != '0) ? pl_r - 1'b1 : pl_r;

    phase_nxt = phase_eff;
    lbc_nxt   = lbc_eff;
    ul_nxt    = ul_eff;
    pl_nxt    = in_first_byte ? 32'd0 : pl_r;
    fl_nxt    = fl_dec;

    push_cmd             = '0;
    push_cmd.data        = in_data_byte;

    unique case (phase_eff)
      PH_LENGTH: begin
        if (lbc_eff == 2'd3) begin
          lbc_nxt = 2'd0;
          ul_nxt  = 24'd0;
          if (ul_new > 32'(fl_dec)) begin
            phase_nxt = PH_STOPPED;
          end else begin
            push_cmd.start_code = en_r;
            pl_nxt              = ul_new;
            phase_nxt           = (ul_new != '0) ? PH_PAYLOAD : PH_LENGTH;
          end
        end else begin
          lbc_nxt = lbc_eff + 2'd1;
          ul_nxt  = ul_new[23:0];
        end
      end
      PH_PAYLOAD: begin
        push_cmd.annexb_byte = en_r;
        pl_nxt               = pl_dec;
        if (pl_dec == '0) begin
          phase_nxt = PH_LENGTH;
        end
      end
      default: begin
        phase_nxt = phase_eff;
      end
    endcase

    // Last byte of the frame: append filler, clear parsing.
    if (fl_dec == '0) begin
      push_cmd.filler = 1'b1;
      phase_nxt       = PH_LENGTH;
      lbc_nxt         = 2'd0;
      ul_nxt          = 24'd0;
      pl_nxt          = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b1;
      phase_r <= PH_LENGTH;
      lbc_r   <= 2'd0;
      ul_r    <= 24'd0;
      pl_r    <= 32'd0;
      fl_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        en_r <= cfg_wr_data;
      end
      if (push) begin
        phase_r <= phase_nxt;
        lbc_r   <= lbc_nxt;
        ul_r    <= ul_nxt;
        pl_r    <= pl_nxt;
        fl_r    <= fl_nxt;
      end
    end
  end

  a_filler_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_cmd.filler |=> phase_r == PH_LENGTH && lbc_r == 2'd0 && fl_r == '0)
    else $error("filler issued without closing the frame");

  a_one_annexb_kind: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !(push_cmd.start_code && push_cmd.annexb_byte))
    else $error("start code and payload byte on the same item");

  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    push && !in_first_byte && phase_r == PH_STOPPED
      |-> !push_cmd.start_code && !push_cmd.annexb_byte)
    else $error("Annex-B output while stopped");

endmodule

>>> sv/avtab_back.sv
module avtab_back
  import avtab_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic       cmd_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_channel,
  output logic [7:0] out_byte,
  output logic       out_frame_end,
  output logic       out_last
);

  localparam logic [1:0] SEG_RELAY = 2'd0;
  localparam logic [1:0] SEG_SC    = 2'd1;
  localparam logic [1:0] SEG_AB    = 2'd2;
  localparam logic [1:0] SEG_FILL  = 2'd3;

  logic [1:0] seg_r, seg_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       valid_r, valid_nxt;
  logic       ch_r;
  logic [7:0] byte_r;
  logic       fe_r;
  logic       last_r;

  logic       load;
  logic       cur_ch;
  logic [7:0] cur_byte;
  logic       cur_fe;
  logic       done;

  assign load = !cmd_empty && (!valid_r || !out_stall);
  assign pop  = load && done;

  always_comb begin
    cur_ch   = 1'b0;
    cur_byte = cmd.data;
    cur_fe   = 1'b0;
    done     = 1'b0;
    seg_nxt  = seg_r;
    cnt_nxt  = cnt_r;

    unique case (seg_r)
      SEG_RELAY: begin
        cnt_nxt = 4'd0;
        if (cmd.start_code) begin
          seg_nxt = SEG_SC;
        end else if (cmd.annexb_byte) begin
          seg_nxt = SEG_AB;
        end else if (cmd.filler) begin
          seg_nxt = SEG_FILL;
        end else begin
          done = 1'b1;
        end
      end
      SEG_SC: begin
        cur_ch   = 1'b1;
        cur_byte = (cnt_r[1:0] == 2'd3) ? 8'h01 : 8'h00;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt = 4'd0;
          if (cmd.annexb_byte) begin
            seg_nxt = SEG_AB;
          end else if (cmd.filler) begin
            seg_nxt = SEG_FILL;
          end else begin
            done = 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      SEG_AB: begin
        cur_ch  = 1'b1;
        cnt_nxt = 4'd0;
        if (cmd.filler) begin
          seg_nxt = SEG_FILL;
        end else begin
          done = 1'b1;
        end
      end
      SEG_FILL: begin
        cur_byte = filler_byte(cnt_r);
        cur_fe   = (cnt_r == 4'hF);
        done     = (cnt_r == 4'hF);
        cnt_nxt  = cnt_r + 4'd1;
      end
      default: begin
        done = 1'b1;
      end
    endcase

    if (done) begin
      seg_nxt = SEG_RELAY;
      cnt_nxt = 4'd0;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r   <= SEG_RELAY;
      cnt_r   <= 4'd0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (load) begin
        seg_r <= seg_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch_r   <= cur_ch;
      byte_r <= cur_byte;
      fe_r   <= cur_fe;
      last_r <= done;
    end
  end

  assign out_valid     = valid_r;
  assign out_channel   = ch_r;
  assign out_byte      = byte_r;
  assign out_frame_end = fe_r;
  assign out_last      = last_r;

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && fe_r |-> last_r && !ch_r)
    else $error("frame end not on the final relay result");

  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> seg_r == SEG_RELAY && cnt_r == 4'd0)
    else $error("sequencer not back at relay after pop");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |=> valid_r && $stable(byte_r) && $stable(last_r))
    else $error("stalled result changed");

endmodule

>>> sv/avcc_to_annexb_with_filler.sv
// AVCC to Annex-B converter with relay copy and filler.
//
// Input channel (in_valid / in_stall): one frame byte per transaction;
// in_first_byte opens a frame whose size is in in_frame_size. Output channel
// (out_valid / out_stall): one byte per transaction, tagged by out_channel
// (0 relay copy, 1 Annex-B), with out_last on the final result of an input
// byte and out_frame_end on the last filler byte of a frame. cfg_wr_en /
// cfg_wr_data write the Annex-B enable; write it only while the block is idle.
//
// Throughput: one result per cycle while the receiver does not stall and the
// queue is not empty. An input byte has one result for its relay copy, plus
// 4 for a start code or 1 for a payload byte, plus 16 on a frame's last byte.
// The output sequencer sets the pace; a 4-entry queue lets the parser run
// ahead and take bursts back to back. The first result of an input byte
// is valid after the queue write and then the output register load.
// Reset clears parser, queue and sequencer and sets the enable to 1.
// When the receiver stalls, hold the output register; the queue fills, then
// in_stall rises. Bytes outside an open frame are taken and dropped.
module avcc_to_annexb_with_filler
  import avtab_pkg::*;
#(
  parameter int FRAME_SIZE_BITS = FRAME_SIZE_BITS_DEF,
  parameter int CMD_FIFO_AW     = CMD_FIFO_AW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_first_byte,
  input  logic [FRAME_SIZE_BITS-1:0] in_frame_size,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_channel,
  output logic [7:0]                 out_byte,
  output logic                       out_frame_end,
  output logic                       out_last
);

  logic push;
  cmd_t push_cmd;
  logic fifo_full;
  logic fifo_empty;
  logic pop;
  cmd_t head_cmd;

  // Parser: classify each frame byte into one command.
  avtab_front #(
    .FRAME_SIZE_BITS (FRAME_SIZE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_frame_size (in_frame_size),
    .push          (push),
    .push_cmd      (push_cmd),
    .fifo_full     (fifo_full)
  );

  // Command queue decoupling parser from the output sequencer.
  avtab_fifo #(
    .W  (CMD_W),
    .AW (CMD_FIFO_AW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_cmd),
    .rd_en   (pop),
    .rd_data (head_cmd),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  // Sequencer: expand each command into output bytes.
  avtab_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (head_cmd),
    .cmd_empty     (fifo_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_channel   (out_channel),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_last      (out_last)
  );

endmodule
